// ----- rtl/ftvp_pkg.sv -----
// ftvp_pkg: shared types and constants for the fix tag=value parser
// used by every module of the parser and by its port checker
// no dependencies
`default_nettype none

package ftvp_pkg;

	// configuration register indexes
	localparam logic REG_DELIMITER    = 1'b0;
	localparam logic REG_CHECKSUM_TAG = 1'b1;

	// register reset values
	localparam logic [7:0]  DELIMITER_RST    = 8'h01;
	localparam logic [19:0] CHECKSUM_TAG_RST = 20'd10;

	// field widths
	localparam int TAG_W    = 20;
	localparam int OFF_W    = 12;
	localparam int LEN_W    = 13;
	localparam int BYTE_W   = 8;
	localparam int STATED_W = 10;
	localparam int CFG_W    = 20;
	localparam int OUT_TDATA_W = 56;

	// saturation limits
	localparam logic [TAG_W-1:0]    TAG_MAX     = 20'hFFFFF;
	localparam logic [TAG_W-1:0]    TAG_SAT_LIM = 20'd104857;
	localparam logic [STATED_W-1:0] STATED_MAX  = 10'd1023;
	localparam logic [OFF_W-1:0]    OFF_MAX     = 12'd4095;
	localparam logic [LEN_W-1:0]    LEN_MAX     = 13'd8191;

	// ascii codes
	localparam logic [7:0] ASCII_EQ   = 8'h3D;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;

	// message status codes
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_TAG   = 2'd1,
		STAT_NO_FIELDS = 2'd2,
		STAT_TOO_LONG  = 2'd3
	} status_t;

	// one result beat
	typedef struct packed {
		logic              field_valid;
		logic [TAG_W-1:0]  tag;
		logic [OFF_W-1:0]  value_offset;
		logic [LEN_W-1:0]  value_length;
		logic [BYTE_W-1:0] value_first;
		logic              message_done;
		status_t           message_status;
		logic              checksum_ok;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/ftvp_parse_core.sv -----
// ftvp_parse_core: per-byte parse state and result logic of the fix parser
// holds the message state registers, builds a result for each accepted beat that completes a field or ends a message
// depends on ftvp_pkg
`default_nettype none

module ftvp_parse_core import ftvp_pkg::*; #(
	parameter int MSG_BYTES = 4096
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last_byte,
	input  wire logic [7:0]        delimiter,
	input  wire logic [TAG_W-1:0]  checksum_tag,
	output result_t                res,
	output logic                   res_valid
);

	localparam int POS_W = $clog2(MSG_BYTES + 1);
	localparam int CW    = (POS_W > LEN_W) ? POS_W : LEN_W;
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MSG_BYTES);
	localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);

	// message state
	logic                in_value_q, in_value_n;
	logic [TAG_W-1:0]    tag_q, tag_n;
	logic                tag_seen_q, tag_seen_n;
	logic                tag_ended_q, tag_ended_n;
	logic [POS_W-1:0]    pos_q, pos_n;
	logic [POS_W-1:0]    vstart_q, vstart_n;
	logic [7:0]          vfirst_q, vfirst_n;
	logic [7:0]          sum_q, sum_n;
	logic [7:0]          fstart_q, fstart_n;
	logic [7:0]          ck_sum_q, ck_sum_n;
	logic [STATED_W-1:0] stated_q, stated_n;
	logic                stated_ok_q, stated_ok_n;
	logic                seen_q, seen_n;
	status_t             err_q, err_n;
	logic [STATED_W-1:0] val_q, val_n;
	logic                val_seen_q, val_seen_n;
	logic                val_ended_q, val_ended_n;

	// scratch
	logic                is_digit;
	logic [7:0]          digit;
	logic [23:0]         tag_mul;
	logic [13:0]         val_mul;
	logic                emit;
	logic [POS_W-1:0]    len;
	logic [CW-1:0]       len_ext;
	logic [CW-1:0]       vstart_ext;
	status_t             status;

	assign is_digit = data_byte inside {[ASCII_ZERO:ASCII_NINE]};
	assign digit    = data_byte - ASCII_ZERO;
	assign tag_mul  = 24'(tag_q) * 24'd10 + 24'(digit);
	assign val_mul  = 14'(val_q) * 14'd10 + 14'(digit);

	// next state and result for the byte on the input
	always_comb begin
		in_value_n  = in_value_q;
		tag_n       = tag_q;
		tag_seen_n  = tag_seen_q;
		tag_ended_n = tag_ended_q;
		pos_n       = pos_q;
		vstart_n    = vstart_q;
		vfirst_n    = vfirst_q;
		sum_n       = sum_q;
		fstart_n    = fstart_q;
		ck_sum_n    = ck_sum_q;
		stated_n    = stated_q;
		stated_ok_n = stated_ok_q;
		seen_n      = seen_q;
		err_n       = err_q;
		val_n       = val_q;
		val_seen_n  = val_seen_q;
		val_ended_n = val_ended_q;
		emit        = 1'b0;
		len         = '0;
		len_ext     = '0;
		vstart_ext  = '0;
		status      = STAT_OK;
		res         = '0;

		if (err_q == STAT_OK) begin
			if (pos_q >= POS_LIMIT) begin
				err_n = STAT_TOO_LONG;
			end else begin
				sum_n = sum_q + data_byte;
				if (!in_value_q) begin
					// tag phase
					if (data_byte == ASCII_EQ) begin
						if (!tag_seen_q) begin
							err_n = STAT_BAD_TAG;
						end else begin
							in_value_n  = 1'b1;
							vstart_n    = pos_q + POS_ONE;
							vfirst_n    = '0;
							val_n       = '0;
							val_seen_n  = 1'b0;
							val_ended_n = 1'b0;
							if (last_byte) begin
								emit = 1'b1;
							end
						end
					end else if (!tag_ended_q && is_digit) begin
						tag_n      = (tag_q > TAG_SAT_LIM || tag_mul > 24'(TAG_MAX)) ?
							TAG_MAX : tag_mul[TAG_W-1:0];
						tag_seen_n = 1'b1;
					end else begin
						tag_ended_n = 1'b1;
					end
				end else begin
					// value phase
					if (data_byte == delimiter) begin
						emit        = 1'b1;
						len         = pos_q - vstart_q;
						in_value_n  = 1'b0;
						tag_n       = '0;
						tag_seen_n  = 1'b0;
						tag_ended_n = 1'b0;
						fstart_n    = sum_n;
					end else begin
						if (pos_q == vstart_q) begin
							vfirst_n = data_byte;
						end
						if (!val_ended_q && is_digit) begin
							val_n      = (val_mul > 14'(STATED_MAX)) ?
								STATED_MAX : val_mul[STATED_W-1:0];
							val_seen_n = 1'b1;
						end else begin
							val_ended_n = 1'b1;
						end
						if (last_byte) begin
							emit = 1'b1;
							len  = pos_q + POS_ONE - vstart_q;
						end
					end
				end
				pos_n = pos_q + POS_ONE;
			end
		end

		// completed field
		if (emit) begin
			len_ext          = CW'(len);
			vstart_ext       = CW'(vstart_n);
			res.field_valid  = 1'b1;
			res.tag          = tag_q;
			res.value_offset = (vstart_ext > CW'(OFF_MAX)) ? OFF_MAX : vstart_ext[OFF_W-1:0];
			res.value_length = (len_ext > CW'(LEN_MAX)) ? LEN_MAX : len_ext[LEN_W-1:0];
			res.value_first  = (len == '0) ? 8'd0 : vfirst_n;
			seen_n           = 1'b1;
			if (tag_q == checksum_tag) begin
				ck_sum_n    = fstart_q;
				stated_n    = val_n;
				stated_ok_n = val_seen_n;
			end
		end

		// end of message: status, checksum, clear
		if (last_byte) begin
			if (err_n != STAT_OK) begin
				status = err_n;
			end else if (seen_n) begin
				status = STAT_OK;
			end else begin
				status = STAT_NO_FIELDS;
			end
			res.message_done   = 1'b1;
			res.message_status = status;
			res.checksum_ok    = (status == STAT_OK) && stated_ok_n &&
				({2'b00, ck_sum_n} == stated_n);
			in_value_n  = 1'b0;
			tag_n       = '0;
			tag_seen_n  = 1'b0;
			tag_ended_n = 1'b0;
			pos_n       = '0;
			vstart_n    = '0;
			vfirst_n    = '0;
			sum_n       = '0;
			fstart_n    = '0;
			ck_sum_n    = '0;
			stated_n    = '0;
			stated_ok_n = 1'b0;
			seen_n      = 1'b0;
			err_n       = STAT_OK;
			val_n       = '0;
			val_seen_n  = 1'b0;
			val_ended_n = 1'b0;
		end
	end

	assign res_valid = emit | last_byte;

	// state registers, advanced on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_value_q  <= 1'b0;
			tag_q       <= '0;
			tag_seen_q  <= 1'b0;
			tag_ended_q <= 1'b0;
			pos_q       <= '0;
			vstart_q    <= '0;
			vfirst_q    <= '0;
			sum_q       <= '0;
			fstart_q    <= '0;
			ck_sum_q    <= '0;
			stated_q    <= '0;
			stated_ok_q <= 1'b0;
			seen_q      <= 1'b0;
			err_q       <= STAT_OK;
			val_q       <= '0;
			val_seen_q  <= 1'b0;
			val_ended_q <= 1'b0;
		end else if (accept) begin
			in_value_q  <= in_value_n;
			tag_q       <= tag_n;
			tag_seen_q  <= tag_seen_n;
			tag_ended_q <= tag_ended_n;
			pos_q       <= pos_n;
			vstart_q    <= vstart_n;
			vfirst_q    <= vfirst_n;
			sum_q       <= sum_n;
			fstart_q    <= fstart_n;
			ck_sum_q    <= ck_sum_n;
			stated_q    <= stated_n;
			stated_ok_q <= stated_ok_n;
			seen_q      <= seen_n;
			err_q       <= err_n;
			val_q       <= val_n;
			val_seen_q  <= val_seen_n;
			val_ended_q <= val_ended_n;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ftvp_out_reg.sv -----
// ftvp_out_reg: result register of the fix parser and output stream packing
// holds one result beat until the sink takes it
// depends on ftvp_pkg
`default_nettype none

module ftvp_out_reg import ftvp_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire result_t                res_in,
	output logic                        ready,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// tag, value_offset, value_length, value_first, message_status, checksum_ok
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	// field_valid
	output logic                        m_axis_tuser,
	output logic                        m_axis_tlast
);

	logic    valid_q;
	result_t res_q;

	// room for a new beat when empty or when the held one leaves now
	assign ready = !valid_q || m_axis_tready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	// stream packing
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {res_q.checksum_ok, res_q.message_status, res_q.value_first,
		res_q.value_length, res_q.value_offset, res_q.tag};
	assign m_axis_tuser  = res_q.field_valid;
	assign m_axis_tlast  = res_q.message_done;

endmodule

`default_nettype wire

// ----- rtl/fix_tag_value_parser.sv -----
// fix_tag_value_parser: top level of the fix tag=value parser
// holds the configuration registers, joins the parse core and result register
// depends on ftvp_pkg, ftvp_parse_core, ftvp_out_reg

// The parser takes one message byte per beat and sustains one byte per clock
// cycle. A byte is decoded in the cycle it is accepted and its result, if it
// has one, sits in the result register on the next cycle. A result appears for
// each completed field and for the byte marked tlast, which carries the message
// status and the checksum check. The input is ready whenever the result
// register is empty or its beat is taken in the same cycle, so only a stalled
// sink with a pending result holds the input back. Delimiter and checksum tag
// are set through the write port while no message is in flight, which is up
// to the user (not enforced); a message over MSG_BYTES bytes is reported too long.
`default_nettype none

module fix_tag_value_parser import ftvp_pkg::*; #(
	parameter int MSG_BYTES = 4096
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write port
	input  wire logic                   cfg_wr_en,
	input  wire logic                   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_wdata,
	// byte stream in
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// data_byte
	input  wire logic [7:0]             s_axis_tdata,
	input  wire logic                   s_axis_tlast,
	// result stream out
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// tag, value_offset, value_length, value_first, message_status, checksum_ok
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	// field_valid
	output logic                        m_axis_tuser,
	output logic                        m_axis_tlast
);

	logic [7:0]       delimiter_q;
	logic [TAG_W-1:0] checksum_tag_q;
	logic             accept;
	logic             res_valid;
	result_t          res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q    <= DELIMITER_RST;
			checksum_tag_q <= CHECKSUM_TAG_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DELIMITER: begin
					delimiter_q <= cfg_wdata[7:0];
				end
				REG_CHECKSUM_TAG: begin
					checksum_tag_q <= cfg_wdata[TAG_W-1:0];
				end
				default: begin
					delimiter_q <= delimiter_q;
				end
			endcase
		end
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	// byte decode
	ftvp_parse_core #(
		.MSG_BYTES(MSG_BYTES)
	) u_parse_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (s_axis_tdata),
		.last_byte   (s_axis_tlast),
		.delimiter   (delimiter_q),
		.checksum_tag(checksum_tag_q),
		.res         (res),
		.res_valid   (res_valid)
	);

	// result register
	ftvp_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept && res_valid),
		.res_in       (res),
		.ready        (s_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ----- rtl/ftvp_checker.sv -----
// ftvp_checker: port-level assertions for the fix tag=value parser
// bound to the top level, sees its ports only
// depends on ftvp_pkg and fix_tag_value_parser
`default_nettype none

module ftvp_checker import ftvp_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tready,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic                   m_axis_tuser,
	input wire logic                   m_axis_tlast
);

	// held result beat stays put while stalled
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// input only waits behind a stalled pending result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a pending result");

	// every result carries a field or ends a message
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
		else $error("result with neither field nor end of message");

	// status fields only on the closing beat, and no pass on a bad message
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast ?
			(m_axis_tdata[54:53] == STAT_OK || !m_axis_tdata[55]) :
			(m_axis_tdata[55:53] == 3'b000)))
		else $error("inconsistent message status or checksum flag");

	// no-fields status never comes with a field
	a_no_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && m_axis_tdata[54:53] == STAT_NO_FIELDS
		|-> !m_axis_tuser)
		else $error("no-fields status on a field beat");

endmodule

bind fix_tag_value_parser ftvp_checker u_ftvp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

// ----- tb/tb_fix_tag_value_parser.sv -----
// tb_fix_tag_value_parser: self-checking bench for the fix tag=value parser
// predicts every result beat from the byte stream and compares it field by field
// depends on ftvp_pkg and fix_tag_value_parser
`default_nettype none

module tb_fix_tag_value_parser import ftvp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MSG_BYTES     = 4096;
	localparam int IDLE_PCT      = 29;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_BYTES   = 230;

	// one byte beat waiting to be sent
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} stream_byte_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic                   cfg_index;
	logic [CFG_W-1:0]       cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata;
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   m_axis_tlast;

	fix_tag_value_parser #(
		.MSG_BYTES(MSG_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// stimulus and expectation stores
	stream_byte_t pending_bytes[$];
	result_t      expected_results[$];
	logic [7:0]   msg_buf[$];

	// predictor copy of the registers
	logic [7:0]        delim_reg;
	logic [TAG_W-1:0]  cs_tag_reg;

	// predictor copy of the message state
	logic              in_val;
	logic [TAG_W-1:0]  tag_acc;
	logic              tag_dig;
	logic              tag_end;
	logic [12:0]       byte_pos;
	logic [12:0]       val_start;
	logic [7:0]        val_first;
	logic [7:0]        run_sum;
	logic [7:0]        fld_sum;
	logic [7:0]        cs_sum;
	logic [STATED_W-1:0] stated;
	logic              stated_ok;
	logic              any_field;
	status_t           err;
	logic [STATED_W-1:0] num_acc;
	logic              num_seen;
	logic              num_end;

	// settings the generator builds messages for
	logic [7:0]        cur_delim;
	logic [TAG_W-1:0]  cur_cs_tag;

	// handshake and pressure control
	logic in_fire;
	logic no_idle;
	logic hold_req;
	logic hold_ack;
	int   hold_left;
	int   stall_cycles;

	// bookkeeping
	int fails;
	int queued;
	int bytes_taken;
	int fields_expected;
	int status_count[4];

	// clear all message state, as after the last byte
	function automatic void clear_state();
		in_val = 1'b0; tag_acc = '0; tag_dig = 1'b0; tag_end = 1'b0;
		byte_pos = '0; val_start = '0; val_first = '0;
		run_sum = '0; fld_sum = '0; cs_sum = '0;
		stated = '0; stated_ok = 1'b0; any_field = 1'b0; err = STAT_OK;
		num_acc = '0; num_seen = 1'b0; num_end = 1'b0;
	endfunction

	// fill the field part of a result and latch checksum data for its tag
	function automatic void emit_field(inout result_t r, input logic [12:0] len);
		r.field_valid  = 1'b1;
		r.tag          = tag_acc;
		r.value_offset = (val_start > OFF_MAX) ? OFF_MAX : val_start[OFF_W-1:0];
		r.value_length = len;
		r.value_first  = (len == 0) ? 8'h00 : val_first;
		any_field = 1'b1;
		if (tag_acc == cs_tag_reg) begin
			cs_sum    = fld_sum;
			stated    = num_acc;
			stated_ok = num_seen;
		end
	endfunction

	// advance the predictor by one accepted byte; returns 1 when a result is due
	function automatic bit parse_byte(input logic [7:0] b, input logic last,
			output result_t r);
		int unsigned acc;
		logic [12:0] p;
		bit emitted;
		status_t st;
		p = byte_pos;
		emitted = 1'b0;
		r = '0;
		if (err == STAT_OK) begin
			if (p >= MSG_BYTES) begin
				err = STAT_TOO_LONG;
			end else begin
				run_sum = run_sum + b;
				if (!in_val) begin
					// tag phase
					if (b == ASCII_EQ) begin
						if (!tag_dig) begin
							err = STAT_BAD_TAG;
						end else begin
							in_val = 1'b1;
							val_start = p + 13'd1;
							val_first = '0;
							num_acc = '0; num_seen = 1'b0; num_end = 1'b0;
							if (last) begin
								emit_field(r, 13'd0);
								emitted = 1'b1;
							end
						end
					end else if (!tag_end && b >= ASCII_ZERO && b <= ASCII_NINE) begin
						acc = tag_acc * 10 + (b - ASCII_ZERO);
						tag_acc = (tag_acc > TAG_SAT_LIM || acc > TAG_MAX) ? TAG_MAX : 20'(acc);
						tag_dig = 1'b1;
					end else begin
						tag_end = 1'b1;
					end
				end else begin
					// value phase
					if (b == delim_reg) begin
						emit_field(r, p - val_start);
						emitted = 1'b1;
						in_val = 1'b0;
						tag_acc = '0; tag_dig = 1'b0; tag_end = 1'b0;
						fld_sum = run_sum;
					end else begin
						if (p == val_start) val_first = b;
						if (!num_end && b >= ASCII_ZERO && b <= ASCII_NINE) begin
							acc = num_acc * 10 + (b - ASCII_ZERO);
							num_acc = (acc > STATED_MAX) ? STATED_MAX : 10'(acc);
							num_seen = 1'b1;
						end else begin
							num_end = 1'b1;
						end
						if (last) begin
							emit_field(r, p + 13'd1 - val_start);
							emitted = 1'b1;
						end
					end
				end
				byte_pos = p + 13'd1;
			end
		end
		// message end: status and checksum verdict
		if (last) begin
			st = (err != STAT_OK) ? err : (any_field ? STAT_OK : STAT_NO_FIELDS);
			r.message_done   = 1'b1;
			r.message_status = st;
			r.checksum_ok    = (st == STAT_OK) && stated_ok && (cs_sum == stated);
			clear_state();
			emitted = 1'b1;
		end
		return emitted;
	endfunction

	function automatic string fmt_result(input result_t r);
		return $sformatf("fv=%0b tag=%0d off=%0d len=%0d first=%02h done=%0b st=%0d ck=%0b",
			r.field_valid, r.tag, r.value_offset, r.value_length, r.value_first,
			r.message_done, r.message_status, r.checksum_ok);
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// byte source: new beat at the falling edge once the previous one is taken
	always @(negedge clk) begin
		stream_byte_t nxt;
		if (arst_n && (!s_axis_tvalid || in_fire)) begin
			if (pending_bytes.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
				nxt = pending_bytes.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= nxt.data;
				s_axis_tlast  <= nxt.last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result sink: random back-pressure plus the long hold on request
	always @(negedge clk) begin
		logic rdy;
		rdy = 1'b0;
		if (arst_n) begin
			if (hold_req != hold_ack) begin
				hold_ack  <= hold_req;
				hold_left <= HOLD_CYCLES;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end else begin
				rdy = no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
		m_axis_tready <= rdy;
	end

	// monitor: register writes, result check, prediction, stall watchdog
	always @(posedge clk) begin
		result_t want;
		result_t got;
		bit has;
		in_fire <= s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_DELIMITER) delim_reg = cfg_wdata[7:0];
				else cs_tag_reg = cfg_wdata[TAG_W-1:0];
			end
			// compare a result beat with the oldest expectation
			if (m_axis_tvalid && m_axis_tready) begin
				got.field_valid    = m_axis_tuser;
				got.tag            = m_axis_tdata[19:0];
				got.value_offset   = m_axis_tdata[31:20];
				got.value_length   = m_axis_tdata[44:32];
				got.value_first    = m_axis_tdata[52:45];
				got.message_done   = m_axis_tlast;
				got.message_status = status_t'(m_axis_tdata[54:53]);
				got.checksum_ok    = m_axis_tdata[55];
				if (expected_results.size() == 0) begin
					if (fails < 10) $display("unexpected result at %0t: %s", $realtime, fmt_result(got));
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (got.field_valid !== want.field_valid || got.tag !== want.tag ||
							got.value_offset !== want.value_offset ||
							got.value_length !== want.value_length ||
							got.value_first !== want.value_first ||
							got.message_done !== want.message_done ||
							got.message_status !== want.message_status ||
							got.checksum_ok !== want.checksum_ok) begin
						if (fails < 10) begin
							$display("mismatch at %0t: expected %s", $realtime, fmt_result(want));
							$display("                 actual   %s", fmt_result(got));
						end
						fails++;
					end
				end
			end
			// predict from an accepted byte
			if (s_axis_tvalid && s_axis_tready) begin
				has = parse_byte(s_axis_tdata, s_axis_tlast, want);
				bytes_taken++;
				if (has) begin
					expected_results.push_back(want);
					if (want.field_valid) fields_expected++;
					if (want.message_done) status_count[want.message_status]++;
				end
			end
			// watchdog on cycles with no beat moving
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
					$display("tb_fix_tag_value_parser NOT OK");
					$finish;
				end
			end
		end
	end

	// message building helpers
	task automatic put(input logic [7:0] b);
		msg_buf.push_back(b);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++) put(s[i]);
	endtask

	task automatic put_num(input int unsigned v);
		put_str($sformatf("%0d", v));
	endtask

	task automatic finish_msg();
		stream_byte_t sb;
		foreach (msg_buf[i]) begin
			sb.data = msg_buf[i];
			sb.last = (i == msg_buf.size() - 1);
			pending_bytes.push_back(sb);
		end
		queued += msg_buf.size();
		msg_buf.delete();
	endtask

	task automatic put_value(input int n);
		logic [7:0] b;
		repeat (n) begin
			if ($urandom_range(99) < 60) begin
				b = 8'(ASCII_ZERO + $urandom_range(9));
			end else begin
				b = 8'($urandom_range(255));
				if (b == cur_delim) b = b ^ 8'h40;
			end
			put(b);
		end
	endtask

	// tag: plain, checksum tag, huge, saturating, junk suffix, leading zeros, broken
	task automatic put_tag();
		int c;
		c = $urandom_range(99);
		if (c < 55) begin
			put_num($urandom_range(1, 200));
		end else if (c < 67) begin
			put_num(32'(cur_cs_tag));
		end else if (c < 77) begin
			put_num($urandom_range(1048575));
		end else if (c < 82) begin
			put_str("99999999");
		end else if (c < 92) begin
			put_num($urandom_range(99));
			put(8'(8'h20 + $urandom_range(15)));
			put_str("7");
		end else if (c < 97) begin
			put_str("007");
		end else if ($urandom_range(1)) begin
			put_str("-5");
		end
	endtask

	// checksum field over the bytes so far, mostly right, sometimes not
	task automatic put_cs_field();
		logic [7:0] s;
		int c;
		s = '0;
		foreach (msg_buf[i]) s += msg_buf[i];
		put_num(32'(cur_cs_tag));
		put(ASCII_EQ);
		c = $urandom_range(99);
		if (c < 70) put_str($sformatf("%03d", s));
		else if (c < 80) put_str($sformatf("%03d", 8'(s + 1 + $urandom_range(254))));
		else if (c < 88) put_str("99999");
		else if (c < 95) put_str("x12");
	endtask

	// one random message: mostly well formed, some noise and odd endings
	task automatic gen_message();
		int nf;
		int e;
		msg_buf.delete();
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(1, 16)) begin
				case ($urandom_range(4))
					0: put(ASCII_EQ);
					1: put(cur_delim);
					2: put(8'(ASCII_ZERO + $urandom_range(9)));
					default: put(8'($urandom_range(255)));
				endcase
			end
		end else begin
			nf = $urandom_range(1, 6);
			for (int f = 0; f < nf; f++) begin
				if (f == nf - 1 && $urandom_range(99) < 60) begin
					put_cs_field();
				end else begin
					put_tag();
					put(ASCII_EQ);
					put_value($urandom_range(10));
				end
				put(cur_delim);
			end
			e = $urandom_range(99);
			// drop the closing delimiter, or leave a dangling tag
			if (e >= 70 && e < 82) void'(msg_buf.pop_back());
			else if (e >= 82) put_num($urandom_range(999));
		end
		finish_msg();
	endtask

	task automatic random_messages(input int target);
		int start;
		start = queued;
		while (queued - start < target) gen_message();
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every byte is sent and every result has come back
	task automatic wait_idle();
		while (pending_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// main sequence
	initial begin
		logic [7:0]       d;
		logic [TAG_W-1:0] t;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0; cfg_index = REG_DELIMITER; cfg_wdata = '0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		in_fire = 1'b0; no_idle = 1'b0; hold_req = 1'b0; hold_ack = 1'b0; hold_left = 0;
		stall_cycles = 0; fails = 0; queued = 0; bytes_taken = 0; fields_expected = 0;
		foreach (status_count[i]) status_count[i] = 0;
		delim_reg = DELIMITER_RST;
		cs_tag_reg = CHECKSUM_TAG_RST;
		cur_delim = DELIMITER_RST;
		cur_cs_tag = CHECKSUM_TAG_RST;
		clear_state();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed messages on reset register values
		put(ASCII_EQ); finish_msg();                    // '=' with no tag digit
		put_str("-5=x"); finish_msg();                  // minus sign before the tag
		put_str("A"); finish_msg();                     // nothing but junk: no fields
		put_str("99999999="); finish_msg();             // saturating tag, '=' as last byte
		put_str("10=000"); put(cur_delim); finish_msg(); // checksum field alone, sum zero
		put_str("1="); put(8'hFF); finish_msg();        // last field with no delimiter
		wait_idle();

		// random phases over a spread of register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin d = 8'h7C;        t = 20'd10;           end
				1: begin d = 8'h00;        t = TAG_MAX;          end
				2: begin d = 8'hFF;        t = 20'd0;            end
				3: begin d = ASCII_EQ;     t = 20'd35;           end
				4: begin d = 8'h35;        t = 20'd7;            end
				default: begin d = DELIMITER_RST; t = CHECKSUM_TAG_RST; end
			endcase
			cur_delim = d;
			cur_cs_tag = t;
			write_reg(REG_DELIMITER, {12'($urandom), d});
			write_reg(REG_CHECKSUM_TAG, t);
			no_idle = (ph == 3);
			random_messages(PHASE_BYTES);
			// hold the sink off while the source keeps offering
			if (ph == 1) hold_req = ~hold_req;
			wait_idle();
		end
		no_idle = 1'b0;

		if (expected_results.size() != 0) fails += expected_results.size();
		$display("covered %0d bytes, %0d fields, %0d results left over",
			bytes_taken, fields_expected, expected_results.size());
		$display("messages by status: ok %0d, bad tag %0d, no fields %0d, too long %0d",
			status_count[0], status_count[1], status_count[2], status_count[3]);
		if (fails == 0) begin
			$display("tb_fix_tag_value_parser OK");
		end else begin
			$display("tb_fix_tag_value_parser NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
